// ----- rtl/core/mafw_pkg.sv -----
// ----------------------------------------------------------------------------
// mafw_pkg
// Shared types, constants and header tables of the MPEG audio frame walker.
// ----------------------------------------------------------------------------
package mafw_pkg;

  localparam int COUNT_BITS = 24;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int DIV_BITS   = 33;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [32:0] TOTAL_MAX = {33{1'b1}};
  localparam logic [23:0] F24_MAX = 24'hFFFFFF;

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_SUM   = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_RESERVED = 2'd1;
  localparam logic [1:0] ERR_SYNC     = 2'd2;
  localparam logic [1:0] ERR_NOFRAME  = 2'd3;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HDR1 = 2'd1;
  localparam logic [1:0] PH_HDR2 = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  version_code;
    logic [1:0]  layer_code;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [10:0] samples_in_frame;
    logic [11:0] frame_bytes;
    logic        padded;
    logic [8:0]  average_kbps;
    logic [23:0] frames_seen;
    logic [1:0]  error_code;
  } out_t;

  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] dividend;
    logic [23:0]         divisor;
  } div_req_t;

  localparam logic [8:0] RATE_V1 [3][16] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}};

  localparam logic [8:0] RATE_V2 [2][16] = '{
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}};

  function automatic logic [8:0] lookup_kbps(logic [1:0] ver, logic [1:0] lay,
                                             logic [3:0] idx);
    logic [8:0] r;
    r = 9'd0;
    unique case (lay)
      2'd3: r = (ver == 2'd3) ? RATE_V1[0][idx] : RATE_V2[0][idx];
      2'd2: r = (ver == 2'd3) ? RATE_V1[1][idx] : RATE_V2[1][idx];
      2'd1: r = (ver == 2'd3) ? RATE_V1[2][idx] : RATE_V2[1][idx];
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] lookup_samples(logic [1:0] ver, logic [1:0] lay);
    logic [10:0] r;
    if (lay == 2'd3) r = 11'd384;
    else if (lay == 2'd2) r = 11'd1152;
    else r = (ver == 2'd3) ? 11'd1152 : 11'd576;
    return r;
  endfunction

  function automatic logic [15:0] lookup_hz(logic [1:0] ver, logic [1:0] sidx);
    logic [15:0] r;
    unique case (sidx)
      2'd1: r = 16'd48000;
      2'd2: r = 16'd32000;
      default: r = 16'd44100;
    endcase
    if (ver == 2'd2) r = r >> 1;
    else if (ver == 2'd0) r = r >> 2;
    return r;
  endfunction

  function automatic logic [23:0] frames_out(logic [COUNT_BITS-1:0] n);
    logic [32:0] w;
    w = 33'(n);
    return (w > 33'(F24_MAX)) ? F24_MAX : w[23:0];
  endfunction

endpackage

// ----- rtl/core/mafw_queue.sv -----
// ----------------------------------------------------------------------------
// mafw_queue
// Front end: accepts input words into a short queue feeding the back end.
// ----------------------------------------------------------------------------
module mafw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mafw_pkg::in_t in_data,
  output logic          q_valid,
  output mafw_pkg::in_t q_word,
  input  logic          q_pop
);
  import mafw_pkg::*;

  in_t                 mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [Q_PTR_BITS:0]   count;
  logic                  push, pop;

  assign in_stall = (count == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_word   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/mafw_div.sv -----
// ----------------------------------------------------------------------------
// mafw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mafw_div (
  input  logic                     clk,
  input  logic                     rst,
  input  mafw_pkg::div_req_t       req,
  output logic                     done,
  output logic [mafw_pkg::DIV_BITS-1:0] quotient
);
  import mafw_pkg::*;

  localparam int CNT_W = $clog2(DIV_BITS + 1);

  logic [24:0]      rem;
  logic [23:0]      dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [24:0]      r2;

  assign r2 = {rem[23:0], quotient[DIV_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy     <= 1'b1;
      done     <= 1'b0;
      cnt      <= CNT_W'(DIV_BITS);
      quotient <= req.dividend;
      rem      <= '0;
      dvs      <= req.divisor;
    end else if (busy) begin
      if (r2 >= {1'b0, dvs}) begin
        rem      <= r2 - {1'b0, dvs};
        quotient <= {quotient[DIV_BITS-2:0], 1'b1};
      end else begin
        rem      <= r2;
        quotient <= {quotient[DIV_BITS-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/mafw_back.sv -----
// ----------------------------------------------------------------------------
// mafw_back
// Back end: header parse, frame skip, counters, length/average and result.
// ----------------------------------------------------------------------------
module mafw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [23:0]    search_limit,
  input  logic           q_valid,
  input  mafw_pkg::in_t  q_word,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output mafw_pkg::out_t out_data
);
  import mafw_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]            st;
  logic [1:0]            phase, ver, lay;
  logic [11:0]           skip;
  logic [32:0]           btot;
  logic [COUNT_BITS-1:0] ftot, miss;
  logic                  is_sum;
  logic [8:0]            f_kbps;
  logic [15:0]           f_hz;
  logic [10:0]           f_smp;
  logic                  f_pad;
  logic [23:0]           f_frames;
  logic [19:0]           prod;

  div_req_t              dreq;
  logic                  div_done;
  logic [DIV_BITS-1:0]   quo;

  logic                  out_free, take;
  logic [7:0]            b;
  logic [8:0]            kbps_c;
  logic                  hunt, rsv, is_frame, sync_over;
  logic [COUNT_BITS-1:0] miss_inc, ftot_new;
  logic [33:0]           btot_sum;
  logic [12:0]           len13;
  logic                  res_load;
  out_t                  res_word;

  mafw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .done     (div_done),
    .quotient (quo)
  );

  assign out_free  = !out_valid || !out_stall;
  assign take      = (st == ST_IDLE) && q_valid && out_free;
  assign q_pop     = take;
  assign b         = q_word.data_byte;
  assign kbps_c    = lookup_kbps(ver, lay, b[7:4]);
  assign miss_inc  = (miss == CNT_MAX) ? miss : miss + 1'b1;
  assign ftot_new  = (ftot == CNT_MAX) ? ftot : ftot + 1'b1;
  assign btot_sum  = {1'b0, btot} + 34'(kbps_c);
  assign len13     = quo[12:0] + 13'(f_pad);
  assign sync_over = 33'(miss_inc) > 33'(search_limit);

  always_comb begin
    hunt     = 1'b0;
    rsv      = 1'b0;
    is_frame = 1'b0;
    if (!q_word.end_of_stream) begin
      unique case (phase)
        PH_HUNT: hunt = 1'b1;
        PH_HDR1: begin
          hunt = 1'b1;
          rsv  = (b[7:5] == 3'b111) && ((b[4:3] == 2'd1) || (b[2:1] == 2'd0));
        end
        PH_HDR2: begin
          is_frame = (kbps_c != 9'd0) && (b[3:2] != 2'd3);
          rsv      = (kbps_c != 9'd0) && (b[3:2] == 2'd3);
          hunt     = !is_frame;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = {{(DIV_BITS-20){1'b0}}, prod};
    dreq.divisor  = {8'd0, f_hz};
    if (take && q_word.end_of_stream && (ftot != '0)) begin
      dreq.start    = 1'b1;
      dreq.dividend = btot;
      dreq.divisor  = 24'(ftot);
    end else if (st == ST_SCALE) begin
      dreq.start    = 1'b1;
      // times 125 = 128 - 2 - 1
      dreq.dividend = ({13'd0, prod} << 7) - ({13'd0, prod} << 1) - {13'd0, prod};
    end
  end

  // result word for this cycle, loaded into the output register
  always_comb begin
    res_load = 1'b0;
    res_word = '0;
    if (take) begin
      if (q_word.end_of_stream) begin
        if (ftot == '0) begin
          res_load            = 1'b1;
          res_word.result_kind = KIND_ERR;
          res_word.error_code  = ERR_NOFRAME;
        end
      end else if (hunt) begin
        if (rsv) begin
          res_load             = 1'b1;
          res_word.result_kind = KIND_ERR;
          res_word.frames_seen = frames_out(ftot);
          res_word.error_code  = ERR_RESERVED;
        end else if (sync_over) begin
          res_load             = 1'b1;
          res_word.result_kind = KIND_ERR;
          res_word.frames_seen = frames_out(ftot);
          res_word.error_code  = ERR_SYNC;
        end
      end
    end else if ((st == ST_DONE) && out_free) begin
      res_load             = 1'b1;
      res_word.frames_seen = f_frames;
      if (is_sum) begin
        res_word.result_kind  = KIND_SUM;
        res_word.average_kbps = quo[8:0];
      end else begin
        res_word.result_kind      = KIND_FRAME;
        res_word.version_code     = ver;
        res_word.layer_code       = lay;
        res_word.bitrate_kbps     = f_kbps;
        res_word.sample_rate_hz   = f_hz;
        res_word.samples_in_frame = f_smp;
        res_word.frame_bytes      = len13[11:0];
        res_word.padded           = f_pad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (res_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_load) out_data <= res_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      phase     <= PH_HUNT;
      ver       <= 2'd0;
      lay       <= 2'd0;
      skip      <= '0;
      btot      <= '0;
      ftot      <= '0;
      miss      <= '0;
    end else begin
      unique case (st)
        ST_IDLE: if (take) begin
          if (q_word.end_of_stream) begin
            phase <= PH_HUNT;
            skip  <= '0;
            miss  <= '0;
            btot  <= '0;
            ftot  <= '0;
            if (ftot != '0) begin
              f_frames <= frames_out(ftot);
              is_sum   <= 1'b1;
              st       <= ST_DIV;
            end
          end else begin
            unique case (phase)
              PH_SKIP: begin
                skip <= skip - 1'b1;
                if (skip == 12'd1) phase <= PH_HUNT;
              end
              PH_HUNT: if (b == 8'hFF) phase <= PH_HDR1;
              PH_HDR1: begin
                if (b[7:5] == 3'b111) begin
                  ver   <= b[4:3];
                  lay   <= b[2:1];
                  phase <= rsv ? PH_HUNT : PH_HDR2;
                end else begin
                  phase <= PH_HUNT;
                end
              end
              default: begin
                phase <= PH_HUNT;
                if (is_frame) begin
                  if (ftot != CNT_MAX) begin
                    ftot <= ftot_new;
                    btot <= btot_sum[33] ? TOTAL_MAX : btot_sum[32:0];
                  end
                  miss     <= '0;
                  f_kbps   <= kbps_c;
                  f_hz     <= lookup_hz(ver, b[3:2]);
                  f_smp    <= lookup_samples(ver, lay);
                  f_pad    <= b[1];
                  f_frames <= frames_out(ftot_new);
                  is_sum   <= 1'b0;
                  st       <= ST_MUL;
                end
              end
            endcase
            if (hunt) begin
              if (!rsv && sync_over) miss <= '0;
              else miss <= miss_inc;
            end
          end
        end
        ST_MUL: begin
          prod <= f_smp * f_kbps;
          st   <= ST_SCALE;
        end
        ST_SCALE: st <= ST_DIV;
        ST_DIV: if (div_done) st <= ST_DONE;
        ST_DONE: if (out_free) begin
          if (!is_sum && (len13 > 13'd3)) begin
            skip  <= 12'(len13 - 13'd3);
            phase <= PH_SKIP;
          end
          st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/mpeg_audio_frame_walker_top.sv -----
// ----------------------------------------------------------------------------
// mpeg_audio_frame_walker_top
// MPEG audio frame header walker: sync hunt, header decode, frame skip, stats.
// ----------------------------------------------------------------------------
// Feed the byte stream one word per handshake; a word with end_of_stream set
// asks for the summary and clears the counters. Ordinary bytes (hunting or
// skipping) pass through the back end without holding it; a completed header
// holds the back end for the multiply, the scale by 125 and the 33-step serial
// divide for the frame length, and an end-of-stream summary while the same
// divider forms the average. A four-word input queue absorbs that stall. The
// output register holds one result; the back end takes its next word only once
// that result is accepted, or in the same cycle as it is accepted.
module mpeg_audio_frame_walker_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mafw_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mafw_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [23:0]    cfg_data
);
  import mafw_pkg::*;

  // search_limit register
  logic [23:0] search_limit;
  logic        q_valid, q_pop;
  in_t         q_word;

  always_ff @(posedge clk) begin
    if (rst) search_limit <= 24'd65535;
    else if (cfg_we) search_limit <= cfg_data;
  end

  mafw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  mafw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .search_limit (search_limit),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

  // back end only pops a word that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // an error result always carries a nonzero code
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind == KIND_ERR) |-> out_data.error_code != ERR_NONE)
    else $error("error result without code");

  // summaries and frames carry no error code
  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind != KIND_ERR) |-> out_data.error_code == ERR_NONE)
    else $error("non-error result with code");

  // a fresh result only loads when the previous one was taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result overwritten while stalled");

endmodule
